@@ src/ssds_pkg.sv @@
package ssds_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int DIG_IDX_W  = 2;

  localparam int VALUE_W    = 14;
  localparam int PART_W     = 7;
  localparam int SEG_W      = 8;
  localparam int SEL_W      = 4;
  localparam int HOLD_W     = 10;
  localparam int BCD_W      = 4;
  localparam int QUOT_W     = 10;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
  localparam logic [PART_W-1:0]  PART_MAX  = 7'd99;

  localparam logic [SEL_W-1:0] SEL_THOU = 4'hE;
  localparam logic [SEL_W-1:0] SEL_HUND = 4'hD;
  localparam logic [SEL_W-1:0] SEL_TENS = 4'hB;
  localparam logic [SEL_W-1:0] SEL_ONES = 4'h7;
  localparam logic [SEL_W-1:0] SEL_NONE = 4'hF;

  localparam logic [HOLD_W-1:0] DWELL_PLAIN = 10'd100;
  localparam logic [HOLD_W-1:0] DWELL_DEC   = 10'd500;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

  // floor(v/10) = (v * RECIP_10) >> RECIP_SHIFT, exact for v < 43690
  localparam logic [16:0] RECIP_10    = 17'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_ENABLE = 3'd0;

  localparam logic [DIG_IDX_W-1:0] IDX_THOU = 2'd0;
  localparam logic [DIG_IDX_W-1:0] IDX_HUND = 2'd1;
  localparam logic [DIG_IDX_W-1:0] IDX_TENS = 2'd2;
  localparam logic [DIG_IDX_W-1:0] IDX_ONES = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic advance;
  } ssds_cmd_t;

  typedef struct packed {
    logic last;
  } ssds_status_t;

  function automatic logic [SEG_W-1:0] seg_font(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEL_W-1:0] digit_sel(input logic [DIG_IDX_W-1:0] idx);
    logic [SEL_W-1:0] s;
    case (idx)
      IDX_THOU: s = SEL_THOU;
      IDX_HUND: s = SEL_HUND;
      IDX_TENS: s = SEL_TENS;
      IDX_ONES: s = SEL_ONES;
      default:  s = SEL_NONE;
    endcase
    return s;
  endfunction

endpackage

@@ src/ssds_ctrl.sv @@
module ssds_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  ssds_pkg::ssds_status_t status,
  output ssds_pkg::ssds_cmd_t    cmd
);
  import ssds_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DIG_IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                   in_tready_r, in_tready_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIG_IDX_W'(NUM_DIGITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_tready && out_tvalid_r) begin
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_tready_nxt  = (state_nxt == ST_IDLE);
    out_tvalid_nxt = (state_nxt == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

@@ src/ssds_datapath.sv @@
module ssds_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssds_pkg::ssds_cmd_t             cmd,
  output ssds_pkg::ssds_status_t          status,
  input  logic                           display_enable,
  input  logic                           req_type,
  input  logic [ssds_pkg::VALUE_W-1:0]   value,
  input  logic [ssds_pkg::PART_W-1:0]    whole_part,
  input  logic [ssds_pkg::PART_W-1:0]    fraction_part,
  output logic [ssds_pkg::SEG_W-1:0]     segments,
  output logic [ssds_pkg::SEL_W-1:0]     digit_select,
  output logic [ssds_pkg::HOLD_W-1:0]    hold_loops,
  output logic                           last
);
  import ssds_pkg::*;

  logic                 blank_r, blank_nxt;
  logic                 dec_r, dec_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [BCD_W-1:0]     dig_r [NUM_DIGITS];
  logic [BCD_W-1:0]     dig_nxt [NUM_DIGITS];

  logic [VALUE_W-1:0]   plain_v;
  logic [PART_W-1:0]    w_sat, f_sat;
  logic [VALUE_W-1:0]   dec_v;
  logic [DIG_IDX_W-1:0] start_idx;
  logic [30:0]          prod;
  logic [QUOT_W-1:0]    quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;

  always_comb begin
    plain_v = (value > VALUE_MAX) ? VALUE_MAX : value;
    w_sat   = (whole_part > PART_MAX) ? PART_MAX : whole_part;
    f_sat   = (fraction_part > PART_MAX) ? PART_MAX : fraction_part;
    dec_v   = ({w_sat, 6'b0} + {1'b0, w_sat, 5'b0}) + {5'b0, w_sat, 2'b0}
              + {7'b0, f_sat};
    if (req_type) begin
      start_idx = (w_sat >= 7'd10) ? IDX_THOU : IDX_HUND;
    end else if (plain_v >= 14'd1000) begin
      start_idx = IDX_THOU;
    end else if (plain_v >= 14'd100) begin
      start_idx = IDX_HUND;
    end else if (plain_v >= 14'd10) begin
      start_idx = IDX_TENS;
    end else begin
      start_idx = IDX_ONES;
    end
  end

  always_comb begin
    prod     = 31'(val_r) * 31'(RECIP_10);
    quot     = prod[RECIP_SHIFT +: QUOT_W];
    quot_x10 = {1'b0, quot, 3'b0} + {3'b0, quot, 1'b0};
    rem_full = val_r - quot_x10;
  end

  always_comb begin
    blank_nxt = blank_r;
    dec_nxt   = dec_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    dig_nxt   = dig_r;
    if (cmd.load) begin
      blank_nxt = !display_enable;
      dec_nxt   = req_type;
      val_nxt   = req_type ? dec_v : plain_v;
      idx_nxt   = display_enable ? start_idx : IDX_ONES;
    end else if (cmd.step) begin
      val_nxt    = {4'b0, quot};
      dig_nxt[0] = rem_full[BCD_W-1:0];
      for (int i = 1; i < NUM_DIGITS; i++) begin
        dig_nxt[i] = dig_r[i-1];
      end
    end else if (cmd.advance) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= 1'b1;
      dec_r   <= 1'b0;
      idx_r   <= IDX_ONES;
    end else begin
      blank_r <= blank_nxt;
      dec_r   <= dec_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    dig_r <= dig_nxt;
  end

  always_comb begin
    if (blank_r) begin
      segments     = '0;
      digit_select = SEL_NONE;
      hold_loops   = '0;
      last         = 1'b1;
    end else begin
      segments     = seg_font(dig_r[idx_r]) | ((dec_r && idx_r == IDX_HUND) ? POINT_BIT : '0);
      digit_select = digit_sel(idx_r);
      hold_loops   = dec_r ? DWELL_DEC : DWELL_PLAIN;
      last         = (idx_r == IDX_ONES);
    end
    status.last = last;
  end

endmodule

@@ src/seven_segment_digit_sequencer_core.sv @@
// Four-digit seven-segment sequencer.
// Input stream: one display request per transaction. in_tuser carries the
// request kind (0 plain integer, 1 whole.fraction); in_tdata carries value,
// whole part and fraction part.
// Output stream: one transaction per lit digit, in display order, with the
// segment pattern, active-low digit select and dwell count; out_tlast marks
// the final digit of the request. With the display disabled a request gives
// one blank transaction (all segments off, no digit selected, dwell 0).
// After a request is accepted, a four-step decimal conversion (one
// divide-by-ten per cycle) runs before the first digit appears.
// Each request shows 1 to 4 digits. Requests are taken one at a time, and
// in_tready is low until the last digit has been taken.
// A stalled receiver holds the current digit on the output until taken.
// Configuration: display_enable at byte address 0 of the APB port, written
// while no request is in flight. Reset (synchronous, active low) clears the
// register to 0 and returns the block to idle, ready for a request.
module seven_segment_digit_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [13:0] value, [20:14] whole_part, [27:21] fraction_part, [31:28] zero
  input  logic [ssds_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] segments, [11:8] digit_select, [21:12] hold_loops, [23:22] zero
  output logic [ssds_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ssds_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ssds_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ssds_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import ssds_pkg::*;

  ssds_cmd_t         cmd;
  ssds_status_t      status;
  logic              display_enable_r, display_enable_nxt;
  logic              reg_hit;
  logic [SEG_W-1:0]  segments;
  logic [SEL_W-1:0]  digit_select;
  logic [HOLD_W-1:0] hold_loops;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == REG_DISPLAY_ENABLE[2]);

  always_comb begin
    display_enable_nxt = display_enable_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      display_enable_nxt = cfg_pwdata[0];
    end
    cfg_prdata = reg_hit ? {{(CFG_DATA_W-1){1'b0}}, display_enable_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_enable_r <= 1'b0;
    end else begin
      display_enable_r <= display_enable_nxt;
    end
  end

  ssds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ssds_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .display_enable (display_enable_r),
    .req_type       (in_tuser),
    .value          (in_tdata[13:0]),
    .whole_part     (in_tdata[20:14]),
    .fraction_part  (in_tdata[27:21]),
    .segments       (segments),
    .digit_select   (digit_select),
    .hold_loops     (hold_loops),
    .last           (out_tlast)
  );

  assign out_tdata = {2'b00, hold_loops, digit_select, segments};

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input ready while a digit is pending");

  a_blank_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && digit_select == SEL_NONE) |-> out_tlast)
    else $error("blank transaction not marked last");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not idle after last digit");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("accepted request did not start conversion");
`endif

endmodule
